[sv/msq_pkg.sv]
// Shared types and constants for the minimal square side packing block.
`default_nettype none

package msq_pkg;

  // Width of the square side and of every search bound.
  localparam int unsigned SIDE_W = 50;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DBL_SETUP,
    S_START_A,
    S_DIV_A,
    S_DIV_B,
    S_CMP,
    S_BS_CHECK
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture a new transaction, hi = 1, lo = 0
    logic x_from_hi;  // test operand x = hi
    logic x_from_mid; // test operand x = midpoint of lo and hi
    logic div_start;  // start the serial divider
    logic div_sel_h;  // divisor is the height (else the width)
    logic save_a;     // keep the first quotient
    logic mul;        // form the product of both quotients
    logic dbl;        // doubling phase: hi = hi * 2
    logic bs_update;  // search phase: move hi or lo by the test result
    logic emit;       // latch hi into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic fits;
    logic lo_lt_hi;
  } sts_t;

endpackage

`default_nettype wire

[sv/msq_div.sv]
// Restoring serial divider: one quotient bit per clock cycle.
`default_nettype none

module msq_div
  import msq_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [SIDE_W-1:0]        dividend,
  input  wire logic [OPERAND_WIDTH-1:0] divisor,
  output logic                          done,
  output logic [SIDE_W-1:0]             quotient
);

  localparam int unsigned CNT_W = $clog2(SIDE_W + 1);
  localparam int unsigned OW    = OPERAND_WIDTH;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [SIDE_W-1:0] quo_r, quo_nxt;
  logic [OW-1:0]     rem_r, rem_nxt;
  logic [OW-1:0]     dvs_r, dvs_nxt;
  logic [OW:0]       shifted;
  logic [OW:0]       diff;
  logic              ge;

  always_comb begin
    shifted  = {rem_r, quo_r[SIDE_W-1]};
    diff     = shifted - {1'b0, dvs_r};
    ge       = (shifted >= {1'b0, dvs_r});
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      cnt_nxt = CNT_W'(SIDE_W);
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
    end else if (cnt_r != '0) begin
      // The dividend shifts out at the top while quotient bits enter below.
      quo_nxt = {quo_r[SIDE_W-2:0], ge};
      rem_nxt = ge ? diff[OW-1:0] : shifted[OW-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

[sv/msq_datapath.sv]
// Datapath: operands, search bounds, shared divider, product and fit test.
`default_nettype none

module msq_datapath
  import msq_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cmd_t              cmd,
  output sts_t                   sts,
  input  wire logic [31:0]       rect_width,
  input  wire logic [31:0]       rect_height,
  input  wire logic [31:0]       rect_count,
  output logic [SIDE_W-1:0]      square_side
);

  localparam int unsigned OW = OPERAND_WIDTH;

  logic [OW-1:0]     w_r, h_r, n_r;
  logic [SIDE_W-1:0] lo_r, hi_r, x_r, out_r;
  logic [OW-1:0]     a_r;
  logic [2*OW-1:0]   prod_r;
  logic [SIDE_W-1:0] mid;
  logic [SIDE_W-1:0] quotient;
  logic [OW-1:0]     q_clamp;
  logic              div_done;
  logic [OW-1:0]     w_in, h_in;

  msq_div #(
    .OPERAND_WIDTH(OW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (x_r),
    .divisor  (cmd.div_sel_h ? h_r : w_r),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    w_in = rect_width[OW-1:0];
    h_in = rect_height[OW-1:0];
    if (w_in == '0) begin
      w_in = OW'(1);
    end
    if (h_in == '0) begin
      h_in = OW'(1);
    end
    mid = lo_r + ((hi_r - lo_r) >> 1);
    // A quotient beyond the operand range already covers any count on its own,
    // so clamping it leaves the outcome of the test unchanged.
    q_clamp = (|quotient[SIDE_W-1:OW]) ? '1 : quotient[OW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w_r  <= w_in;
      h_r  <= h_in;
      n_r  <= rect_count[OW-1:0];
      hi_r <= SIDE_W'(1);
      lo_r <= '0;
    end
    if (cmd.x_from_hi) begin
      x_r <= hi_r;
    end else if (cmd.x_from_mid) begin
      x_r <= mid;
    end
    if (cmd.save_a) begin
      a_r <= q_clamp;
    end
    if (cmd.mul) begin
      prod_r <= a_r * q_clamp;
    end
    if (cmd.dbl) begin
      hi_r <= {hi_r[SIDE_W-2:0], 1'b0};
    end else if (cmd.bs_update) begin
      if (sts.fits) begin
        hi_r <= x_r;
      end else begin
        lo_r <= x_r + 1'b1;
      end
    end
    if (cmd.emit) begin
      out_r <= hi_r;
    end
  end

  assign sts.div_done = div_done;
  assign sts.fits     = (prod_r >= {{OW{1'b0}}, n_r});
  assign sts.lo_lt_hi = (lo_r < hi_r);
  assign square_side  = out_r;

endmodule

`default_nettype wire

[sv/msq_ctrl.sv]
// Controller: sequences the doubling phase, the binary search and the result.
`default_nettype none

module msq_ctrl
  import msq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  output logic      out_valid,
  output cmd_t      cmd,
  input  wire sts_t sts
);

  state_t state_r, state_nxt;
  logic   search_r, search_nxt;
  logic   valid_r, valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      search_r <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      search_r <= search_nxt;
      valid_r  <= valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    search_nxt = search_r;
    valid_nxt  = 1'b0;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          search_nxt = 1'b0;
          state_nxt  = S_DBL_SETUP;
        end
      end
      S_DBL_SETUP: begin
        cmd.x_from_hi = 1'b1;
        state_nxt     = S_START_A;
      end
      S_START_A: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_A;
      end
      S_DIV_A: begin
        if (sts.div_done) begin
          cmd.save_a    = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel_h = 1'b1;
          state_nxt     = S_DIV_B;
        end
      end
      S_DIV_B: begin
        cmd.div_sel_h = 1'b1;
        if (sts.div_done) begin
          cmd.mul   = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (search_r) begin
          cmd.bs_update = 1'b1;
          state_nxt     = S_BS_CHECK;
        end else if (sts.fits) begin
          search_nxt = 1'b1;
          state_nxt  = S_BS_CHECK;
        end else begin
          cmd.dbl   = 1'b1;
          state_nxt = S_DBL_SETUP;
        end
      end
      S_BS_CHECK: begin
        if (sts.lo_lt_hi) begin
          cmd.x_from_mid = 1'b1;
          state_nxt      = S_START_A;
        end else begin
          cmd.emit  = 1'b1;
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = valid_r;

  // The divider finishes only while the controller waits for it.
  assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == S_DIV_A || state_r == S_DIV_B))
    else $error("divider finished outside a wait state");

  // Once the search phase is entered it lasts until the result is out.
  assert property (@(posedge clk) disable iff (!rst_n)
    (search_r && state_r != S_IDLE) |=> (search_r || state_r == S_IDLE))
    else $error("search phase left early");

  // A result is strobed only after the controller has returned to idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (state_r == S_IDLE))
    else $error("result strobe outside idle");

endmodule

`default_nettype wire

[sv/min_square_side_rect_packing.sv]
// Top level of the minimal square side packing block.
//
// Usage: drive in_rect_width, in_rect_height and in_rect_count and raise start;
// the transaction is taken at the rising edge where start is high and busy is
// low. busy stays high while the search runs. The block returns the smallest
// side x with floor(x/w) * floor(x/h) >= count on out_square_side, marked by
// out_valid for exactly one cycle. The receiver cannot stall; the result
// register holds its value until the next result, and a new start is taken in that out_valid cycle.
// Each test of a candidate side runs two 50-step serial divisions on the one
// shared restoring divider, then forms the product and compares it. A
// transaction runs one test per doubling step, one for the passing bound and
// one per search step, at most 98 tests. A new transaction is taken only once
// the previous one has delivered its result.
// Reset returns the controller to idle and drops out_valid; nothing is kept
// between transactions.
`default_nettype none

module min_square_side_rect_packing
  import msq_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [31:0]       in_rect_width,
  input  wire logic [31:0]       in_rect_height,
  input  wire logic [31:0]       in_rect_count,
  output logic                   out_valid,
  output logic [SIDE_W-1:0]      out_square_side
);

  cmd_t cmd;
  sts_t sts;

  msq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  msq_datapath #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .rect_width  (in_rect_width),
    .rect_height (in_rect_height),
    .rect_count  (in_rect_count),
    .square_side (out_square_side)
  );

  // An accepted transaction makes the block busy.
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // A result strobe lasts one cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // busy drops only together with a delivered result.
  assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(busy)) |-> out_valid)
    else $error("busy dropped without a result");

endmodule

`default_nettype wire

[tb/min_square_side_rect_packing_tb.sv]
// Self-checking testbench for the minimal square side packing block.
`timescale 1ns / 100ps

typedef struct packed {
  logic [31:0]                 width;
  logic [31:0]                 height;
  logic [31:0]                 count;
  logic [msq_pkg::SIDE_W-1:0]  side;
} side_job_t;

class side_scoreboard;
  int unsigned operand_w;
  int unsigned mismatches;
  side_job_t   pending_sides[$];

  function new(int unsigned opnd_w);
    operand_w  = opnd_w;
    mismatches = 0;
  endfunction

  // The product of the two quotients saturates instead of wrapping.
  function bit side_fits(bit [63:0] w, bit [63:0] h, bit [63:0] n, bit [63:0] x);
    bit [63:0] a;
    bit [63:0] b;
    bit [63:0] prod;
    a = x / w;
    b = x / h;
    if (a != 0 && b > 64'hFFFF_FFFF_FFFF_FFFF / a) begin
      prod = 64'hFFFF_FFFF_FFFF_FFFF;
    end else begin
      prod = a * b;
    end
    return prod >= n;
  endfunction

  function bit [msq_pkg::SIDE_W-1:0] min_side(bit [31:0] w_in, bit [31:0] h_in,
                                              bit [31:0] n_in);
    bit [63:0] mask;
    bit [63:0] w;
    bit [63:0] h;
    bit [63:0] n;
    bit [63:0] hi;
    bit [63:0] lo;
    bit [63:0] mid;
    int        steps;
    mask = (operand_w >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << operand_w) - 64'd1);
    w = {32'd0, w_in} & mask;
    h = {32'd0, h_in} & mask;
    n = {32'd0, n_in} & mask;
    if (w == 0) w = 1;
    if (h == 0) h = 1;
    hi    = 1;
    lo    = 0;
    steps = 0;
    while (!side_fits(w, h, n, hi) && steps < 62) begin
      hi = hi << 1;
      steps++;
    end
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (side_fits(w, h, n, mid)) begin
        hi = mid;
      end else begin
        lo = mid + 1;
      end
    end
    return hi[msq_pkg::SIDE_W-1:0];
  endfunction

  function void note_rect_set(bit [31:0] w, bit [31:0] h, bit [31:0] n);
    side_job_t job;
    job.width  = w;
    job.height = h;
    job.count  = n;
    job.side   = min_side(w, h, n);
    pending_sides.insert(pending_sides.size(), job);
  endfunction

  function void check_side(logic [msq_pkg::SIDE_W-1:0] got);
    side_job_t job;
    if (pending_sides.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual side %0d", $time, got);
      mismatches++;
    end else begin
      job = pending_sides.pop_front();
      if (got !== job.side) begin
        $display("%0t: square side mismatch for w=%0d h=%0d n=%0d: expected %0d, actual %0d",
                 $time, job.width, job.height, job.count, job.side, got);
        mismatches++;
      end
    end
  endfunction

  function int unsigned outstanding();
    return pending_sides.size();
  endfunction
endclass

module min_square_side_rect_packing_tb
  import msq_pkg::*;
;

  localparam int unsigned OPERAND_WIDTH = 32;
  localparam int unsigned RANDOM_SETS   = 100;
  // After the last result, watch longer than one worst-case transaction
  // for any stray result.
  localparam int unsigned DRAIN_CYCLES  = 11000;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [31:0]       in_rect_width;
  logic [31:0]       in_rect_height;
  logic [31:0]       in_rect_count;
  logic              out_valid;
  logic [SIDE_W-1:0] out_square_side;

  side_scoreboard sb;

  min_square_side_rect_packing #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .in_rect_count  (in_rect_count),
    .out_valid      (out_valid),
    .out_square_side(out_square_side)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(80_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_side(out_square_side);
  end

  // With may_idle set, start is dropped at random cycles while a transaction waits,
  // so the gaps land on every phase of the search, including the cycle in which busy falls.
  task automatic send_rect_set(input logic [31:0] w, input logic [31:0] h,
                               input logic [31:0] n, input bit may_idle);
    bit taken;
    taken          = 1'b0;
    in_rect_width  <= w;
    in_rect_height <= h;
    in_rect_count  <= n;
    while (!taken) begin
      start <= !(may_idle && $urandom_range(0, 99) < 23);
      @(posedge clk);
      taken = start && !busy;
      if (!taken) @(negedge clk);
    end
    sb.note_rect_set(w, h, n);
    @(negedge clk);
  endtask

  // Mix of zero, small, mid-range, near-maximum and full-range values.
  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0:       v = 32'd0;
      1, 2, 3: v = $urandom_range(1, 16);
      4, 5:    v = $urandom_range(1, 65535);
      6:       v = 32'hFFFF_FFFF - $urandom_range(0, 15);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  initial begin
    sb             = new(OPERAND_WIDTH);
    rst_n          = 1'b0;
    start          = 1'b0;
    in_rect_width  = 32'd0;
    in_rect_height = 32'd0;
    in_rect_count  = 32'd0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_rect_set(32'd1, 32'd1, 32'd1, 1'b1);
    send_rect_set(32'd0, 32'd0, 32'd0, 1'b1);
    // A zero dimension counts as one.
    send_rect_set(32'd0, 32'd1, 32'd5, 1'b1);
    send_rect_set(32'd7, 32'd0, 32'd3, 1'b1);
    // A zero count is met by a side of zero.
    send_rect_set(32'd5, 32'd9, 32'd0, 1'b1);
    send_rect_set(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_rect_set(32'd1, 32'd1, 32'hFFFF_FFFF, 1'b1);
    send_rect_set(32'hFFFF_FFFF, 32'd1, 32'd1, 1'b1);
    send_rect_set(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_rect_set(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 1'b1);
    send_rect_set(32'd2, 32'd3, 32'd10, 1'b0);
    send_rect_set(32'h8000_0000, 32'd1, 32'h8000_0000, 1'b0);
    send_rect_set(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    send_rect_set(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
    send_rect_set(32'd3, 32'd3, 32'd2, 1'b1);

    for (int i = 0; i < RANDOM_SETS; i++) begin
      // Transactions 40 to 64 run back to back with start held high.
      send_rect_set(pick_operand(), pick_operand(), pick_operand(), !(i >= 40 && i < 65));
    end
    start <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
